/* rtl/qau_pkg.sv */
package qau_pkg;

   // Word format: signed fixed point, Q8.24 by default.
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;

   // Exact sum of four squares needs two words plus one bit.
   localparam int MAG_BITS  = 2 * WORD_BITS + 1;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int ACC_BITS  = 2 * WORD_BITS + 2;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_MUL = 2'd0;
   localparam kind_type KIND_DIV = 2'd1;
   localparam kind_type KIND_SQR = 2'd2;
   localparam kind_type KIND_INV = 2'd3;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [MAG_BITS-1:0] mag_type;

   // Element 0 is the real part, then i, j, k.
   typedef word_type [3:0] quat_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef struct packed {
      kind_type kind;
      word_type a_real;
      word_type a_i;
      word_type a_j;
      word_type a_k;
      word_type b_real;
      word_type b_i;
      word_type b_j;
      word_type b_k;
   } req_type;

   typedef struct packed {
      word_type res_real;
      word_type res_i;
      word_type res_j;
      word_type res_k;
      logic     overflow;
      logic     divide_by_zero;
   } rsp_type;

   // One pipeline slot of the operands.
   typedef struct packed {
      kind_type kind;
      quat_type a;
      quat_type b;
   } front_type;

   // What one lane hands to the merging stage.
   typedef struct packed {
      word_type value;
      logic     ovf;
   } lane_out_type;

   // Hamilton product: right operand index per row and term.
   localparam logic [1:0] HAM_A [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };

   // Hamilton product: bit t set when term t is subtracted.
   localparam logic [3:0] HAM_N [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

/* rtl/qau_mag.sv */
module qau_mag (
   input  logic              clock,
   input  qau_pkg::quat_type in_b,
   output qau_pkg::mag_type  out_m
);

   localparam int PW = qau_pkg::PROD_BITS;
   localparam int MW = qau_pkg::MAG_BITS;

   logic signed [PW-1:0] sq_in [4];
   logic [PW-1:0]        sq_ff [4];
   logic [MW-1:0]        m_ff;

   // Four squares, one multiplier each.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sq_in[i] = $signed(in_b[i]) * $signed(in_b[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         sq_ff[i] <= sq_in[i];
      end
   end

   // Squares are never negative, so the sum is unsigned and exact.
   always_ff @(posedge clock) begin
      m_ff <= MW'(sq_ff[0]) + MW'(sq_ff[1]) + MW'(sq_ff[2]) + MW'(sq_ff[3]);
   end

   assign out_m = m_ff;

endmodule

/* rtl/qau_div_lane.sv */
module qau_div_lane (
   input  logic                  clock,
   input  qau_pkg::mag_type      in_m,
   input  qau_pkg::word_type     in_b,
   input  logic                  in_flip,
   output qau_pkg::lane_out_type out_inv
);

   localparam int W  = qau_pkg::WORD_BITS;
   localparam int F  = qau_pkg::FRAC_BITS;
   localparam int MW = qau_pkg::MAG_BITS;
   localparam int NW = W + 2 * F;
   localparam int CW = ((NW > MW + W + 1) ? NW : MW + W + 1) + 1;
   localparam int QW = W + 1;
   localparam int NS = W + 1;

   logic [NW-1:0] r_ff   [0:NS];
   logic [QW-1:0] q_ff   [0:NS];
   logic [MW-1:0] m_ff   [0:NS];
   logic          neg_ff [0:NS];
   logic          hi_ff  [0:NS];

   logic [W-1:0]  mag;
   logic [NW-1:0] num;
   logic          hi_in;
   logic [QW-1:0] q;
   logic          sat_pos;
   logic          sat_neg;
   qau_pkg::lane_out_type out_ff;

   // Magnitude of the component, scaled by two fraction widths.
   assign mag   = in_b[W-1] ? W'(~in_b + 1'b1) : W'(in_b);
   assign num   = {mag, {(2*F){1'b0}}};
   // A quotient of 2^(W+1) or more saturates whatever its sign.
   assign hi_in = CW'(num) >= (CW'(in_m) << (W + 1));

   always_ff @(posedge clock) begin
      r_ff[0]   <= num;
      q_ff[0]   <= '0;
      m_ff[0]   <= in_m;
      neg_ff[0] <= in_b[W-1] ^ in_flip;
      hi_ff[0]  <= hi_in;
   end

   // One restoring step per stage, most significant quotient bit first.
   for (genvar s = 1; s <= NS; s++) begin : g_step
      localparam int BIT = NS - s;
      logic [CW-1:0] cand;
      logic          take;

      assign cand = CW'(m_ff[s-1]) << BIT;
      assign take = CW'(r_ff[s-1]) >= cand;

      always_ff @(posedge clock) begin
         r_ff[s]   <= take ? NW'(CW'(r_ff[s-1]) - cand) : r_ff[s-1];
         q_ff[s]   <= q_ff[s-1] | (QW'(take) << BIT);
         m_ff[s]   <= m_ff[s-1];
         neg_ff[s] <= neg_ff[s-1];
         hi_ff[s]  <= hi_ff[s-1];
      end
   end

   // Saturation limits differ by one between the two signs.
   assign q       = q_ff[NS];
   assign sat_pos = hi_ff[NS] | q[W] | q[W-1];
   assign sat_neg = hi_ff[NS] | q[W] | (q[W-1] & (|q[W-2:0]));

   always_ff @(posedge clock) begin
      if (neg_ff[NS]) begin
         out_ff.value <= sat_neg ? qau_pkg::WORD_MIN : W'(~q[W-1:0] + 1'b1);
         out_ff.ovf   <= sat_neg;
      end else begin
         out_ff.value <= sat_pos ? qau_pkg::WORD_MAX : q[W-1:0];
         out_ff.ovf   <= sat_pos;
      end
   end

   assign out_inv = out_ff;

endmodule

/* rtl/qau_mul_lane.sv */
module qau_mul_lane (
   input  logic                  clock,
   input  logic [1:0]            in_row,
   input  qau_pkg::quat_type     in_x,
   input  qau_pkg::quat_type     in_y,
   output qau_pkg::lane_out_type out_res
);

   localparam int W  = qau_pkg::WORD_BITS;
   localparam int F  = qau_pkg::FRAC_BITS;
   localparam int PW = qau_pkg::PROD_BITS;
   localparam int AW = qau_pkg::ACC_BITS;

   logic signed [PW-1:0] p_in  [4];
   logic signed [PW-1:0] p_ff  [4];
   logic [3:0]           neg_ff;
   logic signed [AW-1:0] acc_in;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] sh;
   logic                 fits;
   qau_pkg::lane_out_type out_ff;

   // Four products of this row of the Hamilton product.
   always_comb begin
      for (int t = 0; t < 4; t++) begin
         p_in[t] = $signed(in_x[qau_pkg::HAM_A[in_row][t]]) * $signed(in_y[t]);
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < 4; t++) begin
         p_ff[t] <= p_in[t];
      end
      neg_ff <= qau_pkg::HAM_N[in_row];
   end

   // Exact signed sum of the four terms.
   always_comb begin
      acc_in = '0;
      for (int t = 0; t < 4; t++) begin
         if (neg_ff[t]) begin
            acc_in = acc_in - AW'(p_ff[t]);
         end else begin
            acc_in = acc_in + AW'(p_ff[t]);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Truncate toward minus infinity, then saturate to the word.
   assign sh   = acc_ff >>> F;
   assign fits = (&sh[AW-1:W-1]) | ~(|sh[AW-1:W-1]);

   always_ff @(posedge clock) begin
      if (fits) begin
         out_ff.value <= sh[W-1:0];
      end else begin
         out_ff.value <= sh[AW-1] ? qau_pkg::WORD_MIN : qau_pkg::WORD_MAX;
      end
      out_ff.ovf <= ~fits;
   end

   assign out_res = out_ff;

endmodule

/* rtl/quaternion_arithmetic_unit.sv */
// Throughput: one word per cycle; busy stays low, as the pipeline never stalls.
// The depth is set by the inverse: a 33-stage restoring divider lane per component.
// Reset clears only the valid pipeline; no result strobes for words in flight at reset.
// Results appear in acceptance order and must be taken in the cycle they are shown.
module quaternion_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qau_pkg::req_type req_data,
   output logic             rsp_strobe,
   output qau_pkg::rsp_type rsp_data
);

   localparam int W          = qau_pkg::WORD_BITS;
   localparam int DIV_IDX    = W + 5;
   localparam int MUL_IDX    = W + 8;
   localparam int LAST       = W + 9;
   localparam int LAT_CYCLES = W + 10;

   logic                  accept;
   logic [LAST:0]         vld_ff;
   qau_pkg::front_type    fr_ff [0:DIV_IDX];
   qau_pkg::mag_type      m;
   logic                  dz_ff [3:MUL_IDX];
   qau_pkg::lane_out_type inv [4];
   qau_pkg::lane_out_type mres [4];
   qau_pkg::quat_type     inv_q;
   logic                  inv_ovf;
   qau_pkg::quat_type     mul_x;
   qau_pkg::quat_type     mul_y;
   qau_pkg::quat_type     iv_ff [DIV_IDX+1:MUL_IDX];
   logic                  io_ff [DIV_IDX+1:MUL_IDX];
   qau_pkg::kind_type     kd_ff [DIV_IDX+1:MUL_IDX];
   qau_pkg::quat_type     mul_q;
   logic                  mul_ovf;
   qau_pkg::rsp_type      rsp_ff;

   // Handshake: the pipeline always has room.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAST-1:0], accept};
      end
   end

   // Operand line, carried until the multiply lanes take it.
   always_ff @(posedge clock) begin
      fr_ff[0].kind <= req_data.kind;
      fr_ff[0].a    <= {req_data.a_k, req_data.a_j, req_data.a_i, req_data.a_real};
      fr_ff[0].b    <= {req_data.b_k, req_data.b_j, req_data.b_i, req_data.b_real};
      for (int k = 1; k <= DIV_IDX; k++) begin
         fr_ff[k] <= fr_ff[k-1];
      end
   end

   // Squared magnitude of b.
   qau_mag u_mag (
      .clock (clock),
      .in_b  (fr_ff[0].b),
      .out_m (m)
   );

   // Zero magnitude flag, carried to the merging stage.
   always_ff @(posedge clock) begin
      dz_ff[3] <= (m == '0);
      for (int k = 4; k <= MUL_IDX; k++) begin
         dz_ff[k] <= dz_ff[k-1];
      end
   end

   // One divider lane per component of the inverse; imaginary parts are negated.
   for (genvar i = 0; i < 4; i++) begin : g_div
      qau_div_lane u_div (
         .clock   (clock),
         .in_m    (m),
         .in_b    (fr_ff[2].b[i]),
         .in_flip (1'(i != 0)),
         .out_inv (inv[i])
      );
      assign inv_q[i] = inv[i].value;
   end

   assign inv_ovf = inv[0].ovf | inv[1].ovf | inv[2].ovf | inv[3].ovf;

   // Operand selection for the product lanes.
   always_comb begin
      unique case (fr_ff[DIV_IDX].kind)
         qau_pkg::KIND_MUL: begin
            mul_x = fr_ff[DIV_IDX].a;
            mul_y = fr_ff[DIV_IDX].b;
         end
         qau_pkg::KIND_DIV: begin
            mul_x = fr_ff[DIV_IDX].a;
            mul_y = inv_q;
         end
         qau_pkg::KIND_SQR: begin
            mul_x = fr_ff[DIV_IDX].b;
            mul_y = fr_ff[DIV_IDX].b;
         end
         default: begin
            mul_x = fr_ff[DIV_IDX].a;
            mul_y = fr_ff[DIV_IDX].b;
         end
      endcase
   end

   // One product lane per result component.
   for (genvar i = 0; i < 4; i++) begin : g_mul
      qau_mul_lane u_mul (
         .clock   (clock),
         .in_row  (2'(i)),
         .in_x    (mul_x),
         .in_y    (mul_y),
         .out_res (mres[i])
      );
      assign mul_q[i] = mres[i].value;
   end

   assign mul_ovf = mres[0].ovf | mres[1].ovf | mres[2].ovf | mres[3].ovf;

   // Inverse and kind wait alongside the product lanes.
   always_ff @(posedge clock) begin
      iv_ff[DIV_IDX+1] <= inv_q;
      io_ff[DIV_IDX+1] <= inv_ovf;
      kd_ff[DIV_IDX+1] <= fr_ff[DIV_IDX].kind;
      for (int k = DIV_IDX + 2; k <= MUL_IDX; k++) begin
         iv_ff[k] <= iv_ff[k-1];
         io_ff[k] <= io_ff[k-1];
         kd_ff[k] <= kd_ff[k-1];
      end
   end

   // Merging stage: pick the result and combine the flags.
   always_ff @(posedge clock) begin
      priority if ((kd_ff[MUL_IDX] == qau_pkg::KIND_DIV || kd_ff[MUL_IDX] == qau_pkg::KIND_INV)
                   && dz_ff[MUL_IDX]) begin
         rsp_ff.res_real       <= '0;
         rsp_ff.res_i          <= '0;
         rsp_ff.res_j          <= '0;
         rsp_ff.res_k          <= '0;
         rsp_ff.overflow       <= 1'b0;
         rsp_ff.divide_by_zero <= 1'b1;
      end else if (kd_ff[MUL_IDX] == qau_pkg::KIND_INV) begin
         rsp_ff.res_real       <= iv_ff[MUL_IDX][0];
         rsp_ff.res_i          <= iv_ff[MUL_IDX][1];
         rsp_ff.res_j          <= iv_ff[MUL_IDX][2];
         rsp_ff.res_k          <= iv_ff[MUL_IDX][3];
         rsp_ff.overflow       <= io_ff[MUL_IDX];
         rsp_ff.divide_by_zero <= 1'b0;
      end else begin
         rsp_ff.res_real       <= mul_q[0];
         rsp_ff.res_i          <= mul_q[1];
         rsp_ff.res_j          <= mul_q[2];
         rsp_ff.res_k          <= mul_q[3];
         rsp_ff.overflow       <= mul_ovf |
                                  ((kd_ff[MUL_IDX] == qau_pkg::KIND_DIV) & io_ff[MUL_IDX]);
         rsp_ff.divide_by_zero <= 1'b0;
      end
   end

   assign rsp_strobe = vld_ff[LAST];
   assign rsp_data   = rsp_ff;

   // Every accepted word is followed by its result strobe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT_CYCLES rsp_strobe)
      else $error("result strobe missing after fixed latency");

   // Divide by zero comes only from divide or invert.
   a_dbz_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.divide_by_zero |->
         ($past(kd_ff[MUL_IDX]) == qau_pkg::KIND_DIV ||
          $past(kd_ff[MUL_IDX]) == qau_pkg::KIND_INV))
      else $error("divide by zero flagged for a kind without a divisor");

   // A zero magnitude gives zeros and no overflow.
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.divide_by_zero |->
         !rsp_data.overflow && rsp_data.res_real == '0 && rsp_data.res_i == '0 &&
         rsp_data.res_j == '0 && rsp_data.res_k == '0)
      else $error("divide by zero result is not cleared");

endmodule
